[rtl/tea_block_encrypt_defines.svh]
// assertion macros for the tea block encryptor
// used by the top level; needs a clock named clk and a reset named rst in scope
`ifndef TEA_BLOCK_ENCRYPT_DEFINES_SVH
`define TEA_BLOCK_ENCRYPT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TEA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tea block encrypt check failed");

// next-cycle implication, checked outside reset
`define TEA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tea block encrypt check failed");

`endif

[rtl/tea_pkg.sv]
// shared types, register indexes and the half-round mix function
// no dependencies
package tea_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CFG_INDEX_W = 3;

  typedef logic [WORD_W-1:0] word_t;

  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD_0  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD_1  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD_2  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD_3  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROUND_DELTA = 3'd4;

  localparam word_t KEY_WORD_0_RESET  = 32'd114;
  localparam word_t KEY_WORD_1_RESET  = 32'd514;
  localparam word_t KEY_WORD_2_RESET  = 32'd1919;
  localparam word_t KEY_WORD_3_RESET  = 32'd810;
  localparam word_t ROUND_DELTA_RESET = 32'hdeadbeef;

  typedef struct packed {
    logic  valid;
    word_t lo;
    word_t hi;
    word_t sum;
  } stage_t;

  typedef struct packed {
    word_t key_0;
    word_t key_1;
    word_t key_2;
    word_t key_3;
    word_t delta;
  } key_set_t;

  typedef struct packed {
    logic [1:0] count;
    logic       full;
  } buf_status_t;

  function automatic word_t mix_half(word_t v, word_t sum, word_t ka, word_t kb);
    word_t a;
    word_t b;
    word_t c;
    a = (v << 4) + ka;
    b = v + sum;
    c = (v >> 5) + kb;
    return a ^ b ^ c;
  endfunction

endpackage

[rtl/tea_plain_if.sv]
// valid/ready channel carrying one plaintext block
// depends on tea_pkg
interface tea_plain_if;
  logic          valid;
  logic          ready;
  tea_pkg::word_t plain_low;
  tea_pkg::word_t plain_high;

  modport source (output valid, output plain_low, output plain_high, input ready);
  modport sink (input valid, input plain_low, input plain_high, output ready);
endinterface

[rtl/tea_cipher_if.sv]
// valid/ready channel carrying one ciphertext block
// depends on tea_pkg
interface tea_cipher_if;
  logic          valid;
  logic          ready;
  tea_pkg::word_t cipher_low;
  tea_pkg::word_t cipher_high;

  modport source (output valid, output cipher_low, output cipher_high, input ready);
  modport sink (input valid, input cipher_low, input cipher_high, output ready);
endinterface

[rtl/tea_block_encrypt.sv]
// tea block encryptor: a chain of round cells feeding a two-entry result buffer
// depends on tea_pkg, tea_plain_if, tea_cipher_if, tea_round_cell, tea_out_buf
//
// usage:
//   plain carries one 64-bit block per transaction (plain_low, plain_high);
//   cipher returns one encrypted block per transaction, in order.
//   keys and round delta are written through cfg_we/cfg_index/cfg_data,
//   index 0..3 key words, 4 round delta; other indexes are ignored.
//   write them only while no block is in flight.
// path: one register stage per half round, then the result buffer.
// throughput: one block per cycle while the result buffer is not full;
//   every half round has its own stage.
// reset: clears all stage valid bits and the buffer, loads the default keys
//   and delta 0xdeadbeef.
// stall: the result buffer holds two blocks; while it is full the whole chain
//   holds and plain.ready is low. with one block waiting, new blocks are
//   still taken.
`include "tea_block_encrypt_defines.svh"

module tea_block_encrypt #(
  parameter int unsigned ROUND_COUNT = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [tea_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  tea_pkg::word_t                     cfg_data,
  tea_plain_if.sink                          plain,
  tea_cipher_if.source                       cipher
);

  tea_pkg::key_set_t   keys;
  tea_pkg::stage_t     chain [ROUND_COUNT+1];
  tea_pkg::buf_status_t status;
  logic                adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      keys.key_0 <= tea_pkg::KEY_WORD_0_RESET;
      keys.key_1 <= tea_pkg::KEY_WORD_1_RESET;
      keys.key_2 <= tea_pkg::KEY_WORD_2_RESET;
      keys.key_3 <= tea_pkg::KEY_WORD_3_RESET;
      keys.delta <= tea_pkg::ROUND_DELTA_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tea_pkg::CFG_KEY_WORD_0:  keys.key_0 <= cfg_data;
        tea_pkg::CFG_KEY_WORD_1:  keys.key_1 <= cfg_data;
        tea_pkg::CFG_KEY_WORD_2:  keys.key_2 <= cfg_data;
        tea_pkg::CFG_KEY_WORD_3:  keys.key_3 <= cfg_data;
        tea_pkg::CFG_ROUND_DELTA: keys.delta <= cfg_data;
        default: ;
      endcase
    end
  end

  assign adv         = !status.full;
  assign plain.ready = adv;

  // first round sum is one delta
  assign chain[0].valid = plain.valid;
  assign chain[0].lo    = plain.plain_low;
  assign chain[0].hi    = plain.plain_high;
  assign chain[0].sum   = keys.delta;

  for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
    tea_round_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .keys      (keys),
      .stage_in  (chain[r]),
      .stage_out (chain[r+1])
    );
  end

  tea_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .stage_in (chain[ROUND_COUNT]),
    .status   (status),
    .cipher   (cipher)
  );

  `TEA_ASSERT_IMPL(a_valid_needs_data, cipher.valid, status.count != 2'd0)
  `TEA_ASSERT_NEXT(a_full_holds, status.full && !cipher.ready, !plain.ready)
  `TEA_ASSERT_NEXT(a_stall_keeps_tail, chain[ROUND_COUNT].valid && !adv, chain[ROUND_COUNT].valid)

endmodule

[rtl/tea_round_cell.sv]
// one tea round as two registered half-round stages
// depends on tea_pkg
module tea_round_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  tea_pkg::key_set_t keys,
  input  tea_pkg::stage_t   stage_in,
  output tea_pkg::stage_t   stage_out
);

  tea_pkg::stage_t half;
  tea_pkg::stage_t full;

  always_ff @(posedge clk) begin
    if (rst) begin
      half.valid <= 1'b0;
      full.valid <= 1'b0;
    end else if (adv) begin
      half.valid <= stage_in.valid;
      full.valid <= half.valid;
    end
    if (adv) begin
      // low half update with the current round sum
      half.lo  <= stage_in.lo + tea_pkg::mix_half(stage_in.hi, stage_in.sum,
                                                  keys.key_0, keys.key_1);
      half.hi  <= stage_in.hi;
      half.sum <= stage_in.sum;
      // high half update with the new low half, sum advanced for next round
      full.lo  <= half.lo;
      full.hi  <= half.hi + tea_pkg::mix_half(half.lo, half.sum, keys.key_2, keys.key_3);
      full.sum <= half.sum + keys.delta;
    end
  end

  assign stage_out = full;

endmodule

[rtl/tea_out_buf.sv]
// two-entry result buffer between the round chain and the cipher channel
// depends on tea_pkg and tea_cipher_if
module tea_out_buf (
  input  logic                  clk,
  input  logic                  rst,
  input  tea_pkg::stage_t       stage_in,
  output tea_pkg::buf_status_t  status,
  tea_cipher_if.source          cipher
);

  tea_pkg::word_t lo_mem [2];
  tea_pkg::word_t hi_mem [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;
  logic           pop;

  assign push = stage_in.valid && (count != 2'd2);
  assign pop  = cipher.valid && cipher.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
    if (push) begin
      lo_mem[wr_ptr] <= stage_in.lo;
      hi_mem[wr_ptr] <= stage_in.hi;
    end
  end

  assign cipher.valid       = (count != 2'd0);
  assign cipher.cipher_low  = lo_mem[rd_ptr];
  assign cipher.cipher_high = hi_mem[rd_ptr];

  assign status.count = count;
  assign status.full  = (count == 2'd2);

endmodule

[verif/tea_block_encrypt_tb.sv]
// self-checking testbench for tea_block_encrypt: directed table, then random blocks
// under several key settings and idling mixes, each result checked against a local model or a typed value
// depends on tea_pkg, tea_plain_if, tea_cipher_if and tea_block_encrypt
`timescale 1ns / 1ps

module tea_block_encrypt_tb;

  localparam int unsigned ROUNDS = 32;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned BLOCKS_PER_PHASE = 238;
  localparam int unsigned DIR_COUNT = 25;

  localparam logic [tea_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_FIRST =
    tea_pkg::CFG_ROUND_DELTA + 3'd1;
  localparam logic [tea_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_NEXT =
    tea_pkg::CFG_ROUND_DELTA + 3'd2;
  localparam logic [tea_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_LAST = '1;

  typedef enum logic {ROW_BLOCK, ROW_CFG} row_kind_t;

  typedef struct packed {
    tea_pkg::word_t lo;
    tea_pkg::word_t hi;
  } block_t;

  typedef struct packed {
    row_kind_t                          kind;
    logic [tea_pkg::CFG_INDEX_W-1:0]    index;
    tea_pkg::word_t                     a;
    tea_pkg::word_t                     b;
    logic                               typed;
    block_t                             result;
  } stim_row_t;

  localparam tea_pkg::word_t ONES = 32'hffffffff;
  localparam block_t NO_RESULT = '0;

  localparam stim_row_t DIR_ROWS [DIR_COUNT] = '{
    '{ROW_BLOCK, tea_pkg::CFG_KEY_WORD_0, 32'h0, 32'h0, 1'b0, NO_RESULT},
    '{ROW_BLOCK, tea_pkg::CFG_KEY_WORD_0, ONES, ONES, 1'b0, NO_RESULT},
    '{ROW_BLOCK, tea_pkg::CFG_KEY_WORD_0, ONES, 32'h0, 1'b0, NO_RESULT},
    '{ROW_BLOCK, tea_pkg::CFG_KEY_WORD_0, 32'h0, ONES, 1'b0, NO_RESULT},
    '{ROW_BLOCK, tea_pkg::CFG_KEY_WORD_0, 32'h55555555, 32'haaaaaaaa, 1'b0, NO_RESULT},
    '{ROW_BLOCK, tea_pkg::CFG_KEY_WORD_0, 32'h80000000, 32'h00000001, 1'b0, NO_RESULT},
    '{ROW_BLOCK, tea_pkg::CFG_KEY_WORD_0, 32'h04030201, 32'h08070605, 1'b0, NO_RESULT},
    '{ROW_CFG, CFG_UNUSED_FIRST, ONES, 32'h0, 1'b0, NO_RESULT},
    '{ROW_CFG, CFG_UNUSED_NEXT, 32'h0, 32'h0, 1'b0, NO_RESULT},
    '{ROW_CFG, CFG_UNUSED_LAST, ONES, 32'h0, 1'b0, NO_RESULT},
    '{ROW_BLOCK, tea_pkg::CFG_KEY_WORD_0, 32'h0, 32'h0, 1'b0, NO_RESULT},
    '{ROW_CFG, tea_pkg::CFG_KEY_WORD_0, 32'h0, 32'h0, 1'b0, NO_RESULT},
    '{ROW_CFG, tea_pkg::CFG_KEY_WORD_1, 32'h0, 32'h0, 1'b0, NO_RESULT},
    '{ROW_CFG, tea_pkg::CFG_KEY_WORD_2, 32'h0, 32'h0, 1'b0, NO_RESULT},
    '{ROW_CFG, tea_pkg::CFG_KEY_WORD_3, 32'h0, 32'h0, 1'b0, NO_RESULT},
    '{ROW_CFG, tea_pkg::CFG_ROUND_DELTA, 32'h0, 32'h0, 1'b0, NO_RESULT},
    '{ROW_BLOCK, tea_pkg::CFG_KEY_WORD_0, 32'h0, 32'h0, 1'b1, '{32'h0, 32'h0}},
    '{ROW_BLOCK, tea_pkg::CFG_KEY_WORD_0, 32'h12345678, 32'h9abcdef0, 1'b0, NO_RESULT},
    '{ROW_CFG, tea_pkg::CFG_KEY_WORD_0, ONES, 32'h0, 1'b0, NO_RESULT},
    '{ROW_CFG, tea_pkg::CFG_KEY_WORD_1, ONES, 32'h0, 1'b0, NO_RESULT},
    '{ROW_CFG, tea_pkg::CFG_KEY_WORD_2, ONES, 32'h0, 1'b0, NO_RESULT},
    '{ROW_CFG, tea_pkg::CFG_KEY_WORD_3, ONES, 32'h0, 1'b0, NO_RESULT},
    '{ROW_CFG, tea_pkg::CFG_ROUND_DELTA, ONES, 32'h0, 1'b0, NO_RESULT},
    '{ROW_BLOCK, tea_pkg::CFG_KEY_WORD_0, ONES, ONES, 1'b0, NO_RESULT},
    '{ROW_BLOCK, tea_pkg::CFG_KEY_WORD_0, 32'h0, 32'h0, 1'b0, NO_RESULT}
  };

  logic clk;
  logic rst;
  logic cfg_we;
  logic [tea_pkg::CFG_INDEX_W-1:0] cfg_index;
  tea_pkg::word_t cfg_data;

  tea_plain_if plain_ch ();
  tea_cipher_if cipher_ch ();

  tea_block_encrypt #(
    .ROUND_COUNT(ROUNDS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .plain(plain_ch),
    .cipher(cipher_ch)
  );

  tea_pkg::word_t enc_key [4];
  tea_pkg::word_t enc_delta;
  block_t cipher_q [$];
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  int unsigned blocks_sent;
  int unsigned blocks_checked;
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned key_settings;
  block_t got_block;
  block_t want_block;

  function automatic block_t model_block(tea_pkg::word_t lo_in, tea_pkg::word_t hi_in);
    tea_pkg::word_t lo;
    tea_pkg::word_t hi;
    tea_pkg::word_t sum;
    lo = lo_in;
    hi = hi_in;
    sum = '0;
    for (int r = 0; r < ROUNDS; r++) begin
      sum = sum + enc_delta;
      lo = lo + ((((hi << 4) + enc_key[0]) ^ (hi + sum)) ^ ((hi >> 5) + enc_key[1]));
      hi = hi + ((((lo << 4) + enc_key[2]) ^ (lo + sum)) ^ ((lo >> 5) + enc_key[3]));
    end
    return '{lo, hi};
  endfunction

  function automatic tea_pkg::word_t rand_word();
    tea_pkg::word_t w;
    case ($urandom_range(9))
      6: w = $urandom_range(1) ? ONES : '0;
      7: w = tea_pkg::word_t'(1) << $urandom_range(31);
      8: w = ~(tea_pkg::word_t'(1) << $urandom_range(31));
      9: w = $urandom_range(255);
      default: w = $urandom;
    endcase
    return w;
  endfunction

  task automatic log_error(string what, block_t want, block_t got);
    error_count++;
    if (error_count <= 10) begin
      $display("error: %s at cycle %0d: expected lo=%08h hi=%08h, got lo=%08h hi=%08h",
               what, cycle_count, want.lo, want.hi, got.lo, got.hi);
    end
  endtask

  // called at a falling edge; returns at a falling edge
  task automatic write_reg(logic [tea_pkg::CFG_INDEX_W-1:0] idx, tea_pkg::word_t data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tea_pkg::CFG_KEY_WORD_0: enc_key[0] = data;
      tea_pkg::CFG_KEY_WORD_1: enc_key[1] = data;
      tea_pkg::CFG_KEY_WORD_2: enc_key[2] = data;
      tea_pkg::CFG_KEY_WORD_3: enc_key[3] = data;
      tea_pkg::CFG_ROUND_DELTA: enc_delta = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic push_block(tea_pkg::word_t lo, tea_pkg::word_t hi, logic typed,
                            block_t typed_result);
    block_t want;
    while ($urandom_range(99) < send_gap_pct) begin
      plain_ch.valid <= 1'b0;
      @(negedge clk);
    end
    plain_ch.valid <= 1'b1;
    plain_ch.plain_low <= lo;
    plain_ch.plain_high <= hi;
    want = typed ? typed_result : model_block(lo, hi);
    do @(posedge clk); while (!plain_ch.ready);
    cipher_q.push_back(want);
    blocks_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drain();
    plain_ch.valid <= 1'b0;
    @(negedge clk);
    while (cipher_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cipher_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      cipher_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count, cipher_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && cipher_ch.valid && cipher_ch.ready) begin
      got_block = '{cipher_ch.cipher_low, cipher_ch.cipher_high};
      if (cipher_q.size() == 0) begin
        log_error("result with nothing pending", NO_RESULT, got_block);
      end else begin
        want_block = cipher_q.pop_front();
        blocks_checked++;
        if (got_block.lo !== want_block.lo || got_block.hi !== want_block.hi) begin
          log_error("result mismatch", want_block, got_block);
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    plain_ch.valid = 1'b0;
    plain_ch.plain_low = '0;
    plain_ch.plain_high = '0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    blocks_sent = 0;
    blocks_checked = 0;
    error_count = 0;
    cycle_count = 0;
    key_settings = 1;
    enc_key[0] = tea_pkg::KEY_WORD_0_RESET;
    enc_key[1] = tea_pkg::KEY_WORD_1_RESET;
    enc_key[2] = tea_pkg::KEY_WORD_2_RESET;
    enc_key[3] = tea_pkg::KEY_WORD_3_RESET;
    enc_delta = tea_pkg::ROUND_DELTA_RESET;

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < DIR_COUNT; i++) begin
      if (DIR_ROWS[i].kind == ROW_CFG) begin
        wait_drain();
        write_reg(DIR_ROWS[i].index, DIR_ROWS[i].a);
      end else begin
        push_block(DIR_ROWS[i].a, DIR_ROWS[i].b, DIR_ROWS[i].typed, DIR_ROWS[i].result);
      end
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_drain();
      for (int idx = tea_pkg::CFG_KEY_WORD_0; idx <= tea_pkg::CFG_ROUND_DELTA; idx++) begin
        tea_pkg::word_t value;
        case (phase)
          0: value = '0;
          1: value = ONES;
          2: value = (idx == tea_pkg::CFG_ROUND_DELTA) ? tea_pkg::ROUND_DELTA_RESET :
                     tea_pkg::word_t'($urandom_range(2047));
          3: value = (idx == tea_pkg::CFG_ROUND_DELTA) ? 32'h9e3779b9 :
                     tea_pkg::word_t'($urandom);
          default: value = rand_word();
        endcase
        write_reg(idx[tea_pkg::CFG_INDEX_W-1:0], value);
      end
      key_settings++;
      case (phase % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 49; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 49; end
        default: begin send_gap_pct = 14; recv_stall_pct = 14; end
      endcase
      repeat (BLOCKS_PER_PHASE) push_block(rand_word(), rand_word(), 1'b0, NO_RESULT);
    end

    wait_drain();
    repeat (2 * ROUNDS + 8) @(negedge clk);

    $display("encrypted %0d blocks under %0d key settings, %0d results checked, %0d errors",
             blocks_sent, key_settings, blocks_checked, error_count);
    $display("idling mixes: none, sender gaps, receiver stalls, both");
    if (error_count == 0 && cipher_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
